[rtl/jac_pkg.sv]
`default_nettype none

package jac_pkg;

    localparam int GAIN_W      = 16;
    localparam int DZ_W        = 15;
    localparam int MAG_W       = 15;
    localparam int VALUE_W     = 16;
    localparam int Q_FRAC      = 14;
    localparam int GAIN_SHIFT  = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ONE_Q14     = 16384;
    localparam int FRAC_BITS   = 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [GAIN_W-1:0] POS_GAIN_RST  = 16'd20158;
    localparam logic [GAIN_W-1:0] NEG_GAIN_RST  = 16'd16252;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 15'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_GAIN  = 2'd0,
        CFG_NEG_GAIN  = 2'd1,
        CFG_DEAD_ZONE = 2'd2
    } cfg_index_t;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // one entry of the tan(pi/2*x)/5 curve, Q1.14, Taylor sin/cos in Q2.30
    function automatic logic [MAG_W-1:0] curve_entry(input logic [63:0] idx,
                                                     input logic [63:0] entries);
        logic [63:0] a;
        logic [63:0] st;
        logic [63:0] ct;
        logic [63:0] sp;
        logic [63:0] sn;
        logic [63:0] cp;
        logic [63:0] cn;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] v;
        a  = udiv64(HALF_PI_Q30 * idx, entries);
        st = a;
        ct = 64'd1 << FRAC_BITS;
        sp = st;
        sn = '0;
        cp = ct;
        cn = '0;
        for (int k = 1; k <= 9; k++)
        begin
            st = udiv64((((st * a) >> FRAC_BITS) * a) >> FRAC_BITS,
                        64'((2 * k) * (2 * k + 1)));
            ct = udiv64((((ct * a) >> FRAC_BITS) * a) >> FRAC_BITS,
                        64'((2 * k - 1) * (2 * k)));
            if (k % 2 == 1)
            begin
                sn = sn + st;
                cn = cn + ct;
            end
            else
            begin
                sp = sp + st;
                cp = cp + ct;
            end
        end
        s = (sp > sn) ? sp - sn : 64'd0;
        c = (cp > cn) ? cp - cn : 64'd0;
        if (c == 64'd0)
        begin
            v = 64'(ONE_Q14);
        end
        else
        begin
            v = udiv64((s << Q_FRAC) + ((64'd5 * c) >> 1), 64'd5 * c);
            if (v > 64'(ONE_Q14))
            begin
                v = 64'(ONE_Q14);
            end
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/jac_curve.sv]
`default_nettype none

module jac_curve #(
    parameter int CURVE_ENTRIES = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [jac_pkg::MAG_W-1:0]  mag,
    output logic      [jac_pkg::MAG_W-1:0]  shaped
);

    localparam int IDX_W = $clog2(CURVE_ENTRIES);
    localparam int CE_W  = $clog2(CURVE_ENTRIES + 1);
    localparam int SC_W  = jac_pkg::MAG_W + CE_W;
    localparam int IF_W  = SC_W - jac_pkg::Q_FRAC;

    typedef logic [CURVE_ENTRIES-1:0][jac_pkg::MAG_W-1:0] rom_t;

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < CURVE_ENTRIES; i++)
        begin
            t[i] = jac_pkg::curve_entry(64'(i), 64'(CURVE_ENTRIES));
        end
        return t;
    endfunction

    localparam rom_t CURVE_ROM = build_rom();

    logic [SC_W-1:0]            scaled;
    logic [IF_W-1:0]            idx_full;
    logic                       sat;
    logic [jac_pkg::MAG_W-1:0]  shaped_reg;

    assign scaled   = SC_W'(mag) * SC_W'(CURVE_ENTRIES);
    assign idx_full = scaled[SC_W-1:jac_pkg::Q_FRAC];
    assign sat      = idx_full >= IF_W'(CURVE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shaped_reg <= sat ? jac_pkg::MAG_W'(jac_pkg::ONE_Q14)
                              : CURVE_ROM[idx_full[IDX_W-1:0]];
        end
    end

    assign shaped = shaped_reg;

endmodule

`default_nettype wire

[rtl/joystick_axis_conditioner_top.sv]
`default_nettype none

// Two-axis joystick conditioner. Input words carry one ADC sample of the speed
// (tuser 0) or direction (tuser 1) axis; every word yields exactly one output
// word, in order, after the input register, the gain multiply and the
// registered curve ROM read; one word per clock is sustained unless m_tready
// stalls the output. The first CAL_SAMPLES words of each axis are averaged
// into that axis's center and come out as zero with the calibrating flag set.
// Afterwards the sample is scaled about the center, shaped by the tan curve,
// dead-zoned, and negated on the direction axis. No clearing pass after reset.
module joystick_axis_conditioner_top #(
    parameter int CAL_SAMPLES   = 40,
    parameter int ADC_BITS      = 12,
    parameter int CURVE_ENTRIES = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [((ADC_BITS + 7) / 8) * 8-1:0] s_tdata,  // raw
    input  wire logic                               s_tuser,  // channel
    // master stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [jac_pkg::VALUE_W-1:0]             m_tdata,  // value
    output logic [1:0]                              m_tuser,  // out_channel, calibrating
    // config write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [jac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jac_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W   = ADC_BITS + CNT_W;
    localparam int RSH     = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W = SUM_W + 2;
    localparam int RPROD_W = SUM_W + RECIP_W;
    localparam int PROD_W  = ADC_BITS + jac_pkg::GAIN_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RSH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [CNT_W-1:0] CAL_N = CNT_W'(CAL_SAMPLES);
    localparam int MAG_W = jac_pkg::MAG_W;

    // config
    logic [jac_pkg::GAIN_W-1:0] pos_gain_reg;
    logic [jac_pkg::GAIN_W-1:0] neg_gain_reg;
    logic [jac_pkg::DZ_W-1:0]   dead_zone_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_reg  <= jac_pkg::POS_GAIN_RST;
            neg_gain_reg  <= jac_pkg::NEG_GAIN_RST;
            dead_zone_reg <= jac_pkg::DEAD_ZONE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (jac_pkg::cfg_index_t'(cfg_index))
                jac_pkg::CFG_POS_GAIN:  pos_gain_reg  <= cfg_data;
                jac_pkg::CFG_NEG_GAIN:  neg_gain_reg  <= cfg_data;
                jac_pkg::CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[jac_pkg::DZ_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic in_acc;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_acc   = s_tvalid && rdy1;

    // calibration
    logic [CNT_W-1:0]    count_reg  [2];
    logic [SUM_W-1:0]    sum_reg    [2];
    logic [ADC_BITS-1:0] offset_reg [2];
    logic [ADC_BITS-1:0] raw_in;
    logic                in_cal;
    logic [RPROD_W-1:0]  rprod      [2];

    assign raw_in = s_tdata[ADC_BITS-1:0];
    assign in_cal = count_reg[s_tuser] < CAL_N;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 2; c++)
            begin
                count_reg[c] <= '0;
                sum_reg[c]   <= '0;
            end
        end
        else if (in_acc && in_cal)
        begin
            count_reg[s_tuser] <= count_reg[s_tuser] + 1'b1;
            sum_reg[s_tuser]   <= sum_reg[s_tuser] + SUM_W'(raw_in);
        end
    end

    // mean by reciprocal; settles the cycle after the last sample lands
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            rprod[c] = RPROD_W'(sum_reg[c]) * RPROD_W'(RECIP);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            offset_reg[c] <= rprod[c][RSH +: ADC_BITS];
        end
    end

    // stage 1: input register
    logic                ch1_reg;
    logic                cal1_reg;
    logic [ADC_BITS-1:0] raw1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ch1_reg  <= s_tuser;
            cal1_reg <= in_cal;
            raw1_reg <= raw_in;
        end
    end

    // stage 1 -> 2: gain multiply and clamp
    logic [ADC_BITS-1:0]        off1;
    logic                       above;
    logic [ADC_BITS-1:0]        diff;
    logic [jac_pkg::GAIN_W-1:0] gain;
    logic [PROD_W-1:0]          prod;
    logic [31:0]                p_ext;
    logic [MAG_W-1:0]           mag1;

    assign off1  = offset_reg[ch1_reg];
    assign above = raw1_reg > off1;
    assign diff  = above ? raw1_reg - off1 : off1 - raw1_reg;
    assign gain  = above ? pos_gain_reg : neg_gain_reg;
    assign prod  = PROD_W'(diff) * PROD_W'(gain);
    assign p_ext = 32'(prod >> jac_pkg::GAIN_SHIFT);
    assign mag1  = (p_ext > 32'(jac_pkg::ONE_Q14)) ? MAG_W'(jac_pkg::ONE_Q14)
                                                   : p_ext[MAG_W-1:0];

    logic             ch2_reg;
    logic             cal2_reg;
    logic             neg2_reg;
    logic [MAG_W-1:0] mag2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            ch2_reg  <= ch1_reg;
            cal2_reg <= cal1_reg;
            neg2_reg <= !above ^ ch1_reg;
            mag2_reg <= mag1;
        end
    end

    // stage 2 -> 3: curve lookup
    logic [MAG_W-1:0] shaped3;

    jac_curve #(
        .CURVE_ENTRIES (CURVE_ENTRIES)
    ) u_curve (
        .clk    (clk),
        .en     (rdy3),
        .mag    (mag2_reg),
        .shaped (shaped3)
    );

    logic ch3_reg;
    logic cal3_reg;
    logic neg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            ch3_reg  <= ch2_reg;
            cal3_reg <= cal2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // output: dead zone and sign
    logic [MAG_W-1:0]            kept;
    logic [jac_pkg::VALUE_W-1:0] mag_out;

    assign kept    = (shaped3 < dead_zone_reg) ? '0 : shaped3;
    assign mag_out = jac_pkg::VALUE_W'(kept);

    assign m_tvalid = v3_reg;
    assign m_tuser  = {cal3_reg, ch3_reg};
    assign m_tdata  = cal3_reg ? '0 : (neg3_reg ? -mag_out : mag_out);

`ifndef SYNTHESIS
    a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("calibrating word with nonzero value");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= CAL_N && count_reg[1] <= CAL_N)
        else $error("calibration count past limit");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_cal && !s_tuser |=> count_reg[0] == $past(count_reg[0]) + 1'b1)
        else $error("speed axis calibration count did not advance");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd16384 && $signed(m_tdata) >= -16'sd16384))
        else $error("output value out of range");
`endif

endmodule

`default_nettype wire
